[design/drmm_pkg.sv]
// Package with shared constants for the dual ring modulator mixer with soft clip.
`timescale 1ns / 1ps
package drmm_pkg;
    localparam int unsigned QS = 26;
    localparam longint unsigned ONE_Q = 64'd1 << QS;

    localparam longint unsigned LIMIT_W =
        (64'd1166918530 * ONE_Q + 64'd500000000) / 64'd1000000000;
    localparam logic [26:0] LIMIT_Q = 27'(LIMIT_W);

    localparam logic [39:0] CLAMP_T = 40'(64'd25 * (LIMIT_W + 64'd1));
    localparam logic [32:0] RECIP25 = 33'(((64'd1 << 37) + 64'd24) / 64'd25);

    localparam logic [26:0] K_N13 = 27'((64'd14583300 * ONE_Q + 64'd5000000) / 64'd10000000);
    localparam logic [26:0] K_N25 = 27'((64'd5590280 * ONE_Q + 64'd5000000) / 64'd10000000);
    localparam logic [26:0] K_N37 = 27'((64'd427035 * ONE_Q + 64'd5000000) / 64'd10000000);
    localparam logic [26:0] K_D12 = 27'((64'd15416700 * ONE_Q + 64'd5000000) / 64'd10000000);
    localparam logic [26:0] K_D24 = 27'((64'd6423610 * ONE_Q + 64'd5000000) / 64'd10000000);
    localparam logic [26:0] K_D36 = 27'((64'd579909 * ONE_Q + 64'd5000000) / 64'd10000000);

    localparam logic signed [15:0] NORMAL_B = 16'sd10240;
    localparam logic signed [15:0] NORMAL_C = 16'sd20480;

    localparam logic [2:0] REG_GAIN_B1 = 3'd0;
    localparam logic [2:0] REG_GAIN_C1 = 3'd1;
    localparam logic [2:0] REG_GAIN_B2 = 3'd2;
    localparam logic [2:0] REG_GAIN_C2 = 3'd3;
    localparam logic [2:0] REG_NORMAL  = 3'd4;
    localparam logic [2:0] REG_OUT1_PT = 3'd5;

    localparam int unsigned SUM_W = 50;
    localparam int unsigned CLIP_STAGES = 30;
    localparam int unsigned PIPE_DEPTH = CLIP_STAGES + 3;
endpackage

[design/drmm_clip.sv]
// Pipelined soft clip: rounds and clamps the sum, evaluates the Pade ratio and divides.
`timescale 1ns / 1ps
module drmm_clip (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [drmm_pkg::SUM_W-1:0]     i_sum,
    output logic signed [15:0]                    o_y
);
    localparam int unsigned QS = drmm_pkg::QS;

    logic [28:0] r_neg_sr;
    logic [drmm_pkg::SUM_W-1:0] n_mag;
    logic [drmm_pkg::SUM_W-1:0] n_rnd;
    logic [39:0] r_t;
    logic [63:0] p_rc;
    logic [26:0] r_pq;
    logic        r_clamp;
    logic [26:0] r_x3;

    logic [63:0] p_x2, p_x4, p_x8, p_x12, p_x13, p_x24, p_x25, p_x36, p_x37;
    logic [63:0] p_kn13, p_kd12, p_kd24, p_kn25, p_kd36, p_kn37;

    logic [26:0] r_x_1, r_x2_1;
    logic [26:0] r_x_2, r_x4_2;
    logic [26:0] r_x_3, r_x4_3;
    logic [27:0] r_x8_3;
    logic [26:0] r_x_4;
    logic [28:0] r_x12_4;
    logic [26:0] r_x_5;
    logic [28:0] r_x12_5, r_x13_5;
    logic [31:0] r_x24_5;
    logic [26:0] r_x_6;
    logic [31:0] r_x25_6, r_kn13_6, r_kd12_6, r_kd24_6;
    logic [34:0] r_x36_6;
    logic [26:0] r_x_7;
    logic [34:0] r_x37_7;
    logic [31:0] r_kn13_7, r_kn25_7, r_kd12_7, r_kd24_7, r_kd36_7;
    logic [26:0] r_x_8;
    logic [31:0] r_kn13_8, r_kn25_8, r_kn37_8, r_kd12_8, r_kd24_8, r_kd36_8;
    logic [32:0] r_n9, r_d9;

    logic [48:0] r_rem [0:15];
    logic [32:0] r_dv  [0:15];
    logic [15:0] r_q   [0:16];

    logic [15:0] y_sat;
    logic [16:0] y_neg;

    always_comb begin
        n_mag = i_sum[drmm_pkg::SUM_W-1] ? drmm_pkg::SUM_W'(-i_sum)
                                         : drmm_pkg::SUM_W'(i_sum);
        n_rnd = n_mag + drmm_pkg::SUM_W'(12800);
    end

    assign p_rc  = 64'(r_t[30:0]) * 64'(drmm_pkg::RECIP25);
    assign p_x2  = 64'(r_x3) * 64'(r_x3);
    assign p_x4  = 64'(r_x2_1) * 64'(r_x2_1);
    assign p_x8  = 64'(r_x4_2) * 64'(r_x4_2);
    assign p_x12 = 64'(r_x8_3) * 64'(r_x4_3);
    assign p_x13 = 64'(r_x12_4) * 64'(r_x_4);
    assign p_x24 = 64'(r_x12_4) * 64'(r_x12_4);
    assign p_x25 = 64'(r_x24_5) * 64'(r_x_5);
    assign p_x36 = 64'(r_x24_5) * 64'(r_x12_5);
    assign p_kn13 = 64'(drmm_pkg::K_N13) * 64'(r_x13_5);
    assign p_kd12 = 64'(drmm_pkg::K_D12) * 64'(r_x12_5);
    assign p_kd24 = 64'(drmm_pkg::K_D24) * 64'(r_x24_5);
    assign p_x37 = 64'(r_x36_6) * 64'(r_x_6);
    assign p_kn25 = 64'(drmm_pkg::K_N25) * 64'(r_x25_6);
    assign p_kd36 = 64'(drmm_pkg::K_D36) * 64'(r_x36_6);
    assign p_kn37 = 64'(drmm_pkg::K_N37) * 64'(r_x37_7);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_sr <= {r_neg_sr[27:0], i_sum[drmm_pkg::SUM_W-1]};
            r_t      <= n_rnd[drmm_pkg::SUM_W-1:10];
            r_clamp  <= r_t >= drmm_pkg::CLAMP_T;
            r_pq     <= p_rc[63:37];
            r_x3     <= r_clamp ? drmm_pkg::LIMIT_Q : r_pq;

            r_x_1  <= r_x3;
            r_x2_1 <= p_x2[QS+26:QS];
            r_x_2  <= r_x_1;
            r_x4_2 <= p_x4[QS+26:QS];
            r_x_3  <= r_x_2;
            r_x4_3 <= r_x4_2;
            r_x8_3 <= p_x8[QS+27:QS];
            r_x_4   <= r_x_3;
            r_x12_4 <= p_x12[QS+28:QS];
            r_x_5   <= r_x_4;
            r_x12_5 <= r_x12_4;
            r_x13_5 <= p_x13[QS+28:QS];
            r_x24_5 <= p_x24[QS+31:QS];
            r_x_6    <= r_x_5;
            r_x25_6  <= p_x25[QS+31:QS];
            r_x36_6  <= p_x36[QS+34:QS];
            r_kn13_6 <= p_kn13[QS+31:QS];
            r_kd12_6 <= p_kd12[QS+31:QS];
            r_kd24_6 <= p_kd24[QS+31:QS];
            r_x_7    <= r_x_6;
            r_x37_7  <= p_x37[QS+34:QS];
            r_kn13_7 <= r_kn13_6;
            r_kn25_7 <= p_kn25[QS+31:QS];
            r_kd12_7 <= r_kd12_6;
            r_kd24_7 <= r_kd24_6;
            r_kd36_7 <= p_kd36[QS+31:QS];
            r_x_8    <= r_x_7;
            r_kn13_8 <= r_kn13_7;
            r_kn25_8 <= r_kn25_7;
            r_kn37_8 <= p_kn37[QS+31:QS];
            r_kd12_8 <= r_kd12_7;
            r_kd24_8 <= r_kd24_7;
            r_kd36_8 <= r_kd36_7;
            r_n9 <= 33'(r_x_8) + 33'(r_kn13_8) + 33'(r_kn25_8) + 33'(r_kn37_8);
            r_d9 <= 33'(drmm_pkg::ONE_Q) + 33'(r_kd12_8) + 33'(r_kd24_8) + 33'(r_kd36_8);

            r_rem[0] <= (49'(r_n9) << 14) + (49'(r_n9) << 12) + 49'(r_d9 >> 1);
            r_dv[0]  <= r_d9;
            r_q[0]   <= '0;
        end
    end

    for (genvar g = 0; g < 16; g++) begin : g_div
        logic [48:0] dsh;
        logic        ge;
        assign dsh = 49'(r_dv[g]) << (15 - g);
        assign ge  = r_rem[g] >= dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g+1] <= {r_q[g][14:0], ge};
            end
        end
        if (g < 15) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g+1] <= ge ? r_rem[g] - dsh : r_rem[g];
                    r_dv[g+1]  <= r_dv[g];
                end
            end
        end
    end

    always_comb begin
        y_sat = (r_q[16] > 16'd32768) ? 16'd32768 : r_q[16];
        y_neg = 17'd0 - 17'(y_sat);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg_sr[28]) begin
                o_y <= y_neg[15:0];
            end else begin
                o_y <= (y_sat > 16'd32767) ? 16'sd32767 : y_sat;
            end
        end
    end
endmodule

[design/dual_ring_mod_mixer_soft_clip.sv]
// Top level of the dual ring modulator mixer with soft clip.
// Usage: one input word carries the six samples of both sections (2048 LSB per volt).
// A word is taken when i_in_valid is high and o_in_stall is low; a result word is
// taken when o_out_valid is high and i_out_stall is low. Each input word gives
// exactly one result word with both clipped outputs.
// The pipeline takes one word per cycle unless a valid result word is stalled.
// Its depth is set by the 16-stage divider that forms the Pade ratio, plus the
// multiplier chain for the powers of x.
// When the receiver stalls a valid result word, the whole pipeline holds and
// o_in_stall rises in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and returns the gains to zero, the normal mask to all
// inputs unpatched and the output one patch flag to clear. The block relies on the user
// to write registers via i_cfg_we, i_cfg_addr and i_cfg_wdata only while idle.
`timescale 1ns / 1ps
module dual_ring_mod_mixer_soft_clip (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_a1_sample,
    input  logic signed [15:0] i_b1_sample,
    input  logic signed [15:0] i_c1_sample,
    input  logic signed [15:0] i_a2_sample,
    input  logic signed [15:0] i_b2_sample,
    input  logic signed [15:0] i_c2_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_out1_sample,
    output logic signed [15:0] o_out2_sample
);
    localparam int unsigned DEPTH = drmm_pkg::PIPE_DEPTH;
    localparam int unsigned SW = drmm_pkg::SUM_W;

    logic signed [15:0] r_gain_b1, r_gain_b2;
    logic signed [14:0] r_gain_c1, r_gain_c2;
    logic [3:0]         r_normal;
    logic               r_out1_pt;

    logic [DEPTH-1:0]   r_vld;
    logic               en;

    logic signed [15:0] b1e, c1e, b2e, c2e;
    logic signed [31:0] r_ab1, r_ab2;
    logic signed [30:0] r_cg1, r_cg2;
    logic signed [47:0] r_t1, r_t2;
    logic signed [44:0] r_u1, r_u2;
    logic signed [SW-1:0] r_s1, r_s2;
    logic signed [SW-1:0] sec1;

    assign en = !(r_vld[DEPTH-1] && i_out_stall);
    assign o_in_stall = !en;
    assign o_out_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_b1 <= '0;
            r_gain_c1 <= '0;
            r_gain_b2 <= '0;
            r_gain_c2 <= '0;
            r_normal  <= 4'hF;
            r_out1_pt <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                drmm_pkg::REG_GAIN_B1: r_gain_b1 <= i_cfg_wdata;
                drmm_pkg::REG_GAIN_C1: r_gain_c1 <= i_cfg_wdata[14:0];
                drmm_pkg::REG_GAIN_B2: r_gain_b2 <= i_cfg_wdata;
                drmm_pkg::REG_GAIN_C2: r_gain_c2 <= i_cfg_wdata[14:0];
                drmm_pkg::REG_NORMAL:  r_normal  <= i_cfg_wdata[3:0];
                drmm_pkg::REG_OUT1_PT: r_out1_pt <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
        end
    end

    always_comb begin
        b1e = r_normal[0] ? drmm_pkg::NORMAL_B : i_b1_sample;
        c1e = r_normal[1] ? drmm_pkg::NORMAL_C : i_c1_sample;
        b2e = r_normal[2] ? drmm_pkg::NORMAL_B : i_b2_sample;
        c2e = r_normal[3] ? drmm_pkg::NORMAL_C : i_c2_sample;
        sec1 = SW'(r_t1) + SW'(r_u1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ab1 <= i_a1_sample * b1e;
            r_ab2 <= i_a2_sample * b2e;
            r_cg1 <= c1e * r_gain_c1;
            r_cg2 <= c2e * r_gain_c2;
            r_t1  <= r_ab1 * r_gain_b1;
            r_t2  <= r_ab2 * r_gain_b2;
            r_u1  <= (45'(r_cg1) <<< 13) + (45'(r_cg1) <<< 11);
            r_u2  <= (45'(r_cg2) <<< 13) + (45'(r_cg2) <<< 11);
            r_s1  <= sec1;
            r_s2  <= SW'(r_t2) + SW'(r_u2) + (r_out1_pt ? SW'(0) : sec1);
        end
    end

    drmm_clip u_clip1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_sum (r_s1),
        .o_y   (o_out1_sample)
    );

    drmm_clip u_clip2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_sum (r_s2),
        .o_y   (o_out2_sample)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid && r_vld == '0)
        else $error("pipeline not empty after reset");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(r_vld))
        else $error("valid bits moved while the output was stalled");
    a_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !i_in_valid) |=> !r_vld[0])
        else $error("a word appeared without an accepted input");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[DEPTH-2]) |=> o_out_valid)
        else $error("a word was lost between the last two stages");
endmodule
